@@ rtl/core/hrht_pkg.sv @@
// Shared widths, byte codes and result codes for the HTTP request head tokenizer.
package hrht_pkg;

    // Width of the token length counter; the counter saturates at all ones.
    localparam int unsigned LENGTH_BITS = 12;

    // Stream widths: tdata is event, length and error packed and padded to bytes.
    localparam int unsigned IN_DATA_W   = 8;
    localparam int unsigned OUT_FIELD_W = 3 + LENGTH_BITS + 3;
    localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int unsigned OUT_USER_W  = 4;

    typedef logic [LENGTH_BITS-1:0] t_len;

    // Character codes the tokenizer reacts to.
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Token kinds.
    localparam logic [2:0] KIND_SEP     = 3'd0;
    localparam logic [2:0] KIND_METHOD  = 3'd1;
    localparam logic [2:0] KIND_URI     = 3'd2;
    localparam logic [2:0] KIND_VERSION = 3'd3;
    localparam logic [2:0] KIND_KEY     = 3'd4;
    localparam logic [2:0] KIND_VALUE   = 3'd5;

    // Token end events.
    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_METHOD_END  = 3'd1;
    localparam logic [2:0] EV_URI_END     = 3'd2;
    localparam logic [2:0] EV_VERSION_END = 3'd3;
    localparam logic [2:0] EV_KEY_END     = 3'd4;
    localparam logic [2:0] EV_VALUE_END   = 3'd5;
    localparam logic [2:0] EV_HEAD_END    = 3'd6;

    // Sticky error codes.
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_METHOD  = 3'd1;
    localparam logic [2:0] ERR_URI     = 3'd2;
    localparam logic [2:0] ERR_VERSION = 3'd3;
    localparam logic [2:0] ERR_CRLF    = 3'd4;
    localparam logic [2:0] ERR_KEY     = 3'd5;

    // Increment a token length, holding at the maximum.
    function automatic t_len len_sat_inc(input t_len v);
        t_len res;
        res = (v == '1) ? v : v + t_len'(1);
        return res;
    endfunction

endpackage

@@ rtl/core/http_request_head_tokenizer_unit.sv @@
// Top level of the HTTP request head tokenizer: byte classifier and stage tracker.
//
// Usage: request head octets enter on the slave stream, one per transfer, in
// i_s_axis_tdata. Every accepted octet produces exactly one result transfer on
// the master stream: token end event, token length and sticky error code in
// o_m_axis_tdata, token kind and the past-head flag in o_m_axis_tuser.
// The result of a byte is registered when the byte is accepted and is offered
// from the next cycle on. Throughput is one byte per cycle while the receiver
// does not stall; the stage update is a short decode of the byte against the
// current stage, done between the accepted byte and the result register.
// The result register doubles as the output holding stage: while the receiver
// stalls, the held result stays put and o_s_axis_tready drops; as soon as the
// receiver takes the result, a new byte is taken in the same cycle.
// Once an error is flagged the tokenizer stays halted and reports only the
// error code until reset. After the blank line that ends the head, every byte
// is reported with past_head set.
// Reset (i_rst_n low, synchronous) returns to waiting for the method, clears
// the length counter and the error, and empties the result register.
module http_request_head_tokenizer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Slave stream; tdata: data_byte[7:0].
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [hrht_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // Master stream; tdata: token_event[2:0], token_length[14:3], error_code[17:15],
    // zero fill above.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [hrht_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // tuser: token_kind[2:0], past_head[3].
    output logic [hrht_pkg::OUT_USER_W-1:0]  o_m_axis_tuser
);
    import hrht_pkg::*;

    typedef enum logic [3:0] {
        ST_METHOD  = 4'd0,
        ST_SEP_URI = 4'd1,
        ST_URI     = 4'd2,
        ST_SEP_VER = 4'd3,
        ST_VERSION = 4'd4,
        ST_EOL     = 4'd5,
        ST_LINE    = 4'd6,
        ST_LINE_CR = 4'd7,
        ST_KEY     = 4'd8,
        ST_SEP_VAL = 4'd9,
        ST_VALUE   = 4'd10,
        ST_PAST    = 4'd11
    } t_stage;

    t_stage     r_stage, n_stage;
    t_len       r_count, n_count;
    logic [2:0] r_err, n_err;

    logic       r_valid;
    logic [2:0] r_kind, r_event, r_err_out;
    t_len       r_len;
    logic       r_past;

    logic       accept;
    logic [7:0] b;
    logic       is_blank, is_eol;
    t_len       cnt_inc, val_base;
    logic [2:0] c_kind, c_event;
    t_len       c_len;
    logic       c_past;

    // The result register frees up when it is empty or being taken.
    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Byte classes.
    assign b        = i_s_axis_tdata;
    assign is_blank = b inside {CH_SP, CH_TAB};
    assign is_eol   = b inside {CH_CR, CH_LF};
    assign cnt_inc  = len_sat_inc(r_count);
    assign val_base = len_sat_inc((r_stage == ST_SEP_VAL) ? '0 : r_count);

    // Stage decode for one byte.
    always_comb begin
        n_stage = r_stage;
        n_count = r_count;
        n_err   = r_err;
        c_kind  = KIND_SEP;
        c_event = EV_NONE;
        c_len   = '0;
        c_past  = 1'b0;
        if (r_err == ERR_NONE) begin
            case (r_stage)
                ST_PAST: begin
                    c_past = 1'b1;
                end
                ST_METHOD, ST_URI: begin
                    if (is_blank && r_count != '0) begin
                        c_event = (r_stage == ST_METHOD) ? EV_METHOD_END : EV_URI_END;
                        c_len   = r_count;
                        n_count = '0;
                        n_stage = (r_stage == ST_METHOD) ? ST_SEP_URI : ST_SEP_VER;
                    end else if (is_blank || is_eol) begin
                        n_err = (r_stage == ST_METHOD) ? ERR_METHOD : ERR_URI;
                    end else begin
                        n_count = cnt_inc;
                        c_kind  = (r_stage == ST_METHOD) ? KIND_METHOD : KIND_URI;
                        c_len   = cnt_inc;
                    end
                end
                ST_KEY: begin
                    if (b == CH_COLON && r_count != '0) begin
                        c_event = EV_KEY_END;
                        c_len   = r_count;
                        n_count = '0;
                        n_stage = ST_SEP_VAL;
                    end else if (b == CH_COLON || is_blank || is_eol) begin
                        n_err = ERR_KEY;
                    end else begin
                        n_count = cnt_inc;
                        c_kind  = KIND_KEY;
                        c_len   = cnt_inc;
                    end
                end
                ST_SEP_URI, ST_SEP_VER: begin
                    if (is_eol) begin
                        n_err = (r_stage == ST_SEP_URI) ? ERR_URI : ERR_VERSION;
                    end else if (!is_blank) begin
                        n_stage = (r_stage == ST_SEP_URI) ? ST_URI : ST_VERSION;
                        n_count = t_len'(1);
                        c_kind  = (r_stage == ST_SEP_URI) ? KIND_URI : KIND_VERSION;
                        c_len   = t_len'(1);
                    end
                end
                ST_VERSION, ST_VALUE, ST_SEP_VAL: begin
                    if (is_eol) begin
                        c_event = (r_stage == ST_VERSION) ? EV_VERSION_END : EV_VALUE_END;
                        c_len   = r_count;
                        n_count = '0;
                        n_stage = (b == CH_CR) ? ST_EOL : ST_LINE;
                    end else if (!(r_stage == ST_SEP_VAL && is_blank)) begin
                        // A value starts fresh on its first non-blank byte.
                        if (r_stage == ST_SEP_VAL) begin
                            n_stage = ST_VALUE;
                        end
                        n_count = val_base;
                        c_kind  = (r_stage == ST_VERSION) ? KIND_VERSION : KIND_VALUE;
                        c_len   = val_base;
                    end
                end
                ST_EOL: begin
                    if (b == CH_LF) begin
                        n_stage = ST_LINE;
                    end else if (b != CH_CR) begin
                        n_err = ERR_CRLF;
                    end
                end
                ST_LINE, ST_LINE_CR: begin
                    if (b == CH_CR) begin
                        n_stage = ST_LINE_CR;
                    end else if (b == CH_LF) begin
                        c_event = EV_HEAD_END;
                        n_stage = ST_PAST;
                    end else if (r_stage == ST_LINE_CR || b == CH_COLON || is_blank) begin
                        n_err = ERR_KEY;
                    end else begin
                        n_stage = ST_KEY;
                        n_count = t_len'(1);
                        c_kind  = KIND_KEY;
                        c_len   = t_len'(1);
                    end
                end
                default: begin
                    // Unused stage codes behave as halted.
                end
            endcase
        end
        // An error, old or new, blanks the token report.
        if (n_err != ERR_NONE) begin
            c_kind  = KIND_SEP;
            c_event = EV_NONE;
            c_len   = '0;
            c_past  = 1'b0;
        end
    end

    // Parser state, advanced on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_METHOD;
            r_count <= '0;
            r_err   <= ERR_NONE;
        end else if (accept) begin
            r_stage <= n_stage;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= c_kind;
            r_event   <= c_event;
            r_len     <= c_len;
            r_err_out <= n_err;
            r_past    <= c_past;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_err_out, r_len, r_event});
    assign o_m_axis_tuser  = {r_past, r_kind};

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the HTTP request head tokenizer with a built-in token tracker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrht_pkg::*;

    // Cycles without any transfer before the run is declared hung.
    localparam int unsigned IDLE_LIMIT   = 400;
    // Head bytes sent on the long random path, and the least total byte count of a run.
    localparam int unsigned RANDOM_BYTES = 1900;
    localparam int unsigned ITEM_TARGET  = 2000;
    // Bytes sent after the head has ended or the tokenizer has halted.
    localparam int unsigned TAIL_BYTES   = 64;

    // Parse stages, in the encoding of the tokenizer's stage register.
    typedef enum logic [3:0] {
        ST_METHOD, ST_SEP_URI, ST_URI, ST_SEP_VER, ST_VERSION, ST_EOL,
        ST_LINE, ST_LINE_CR, ST_KEY, ST_SEP_VAL, ST_VALUE, ST_PAST
    } t_stage;

    // Everything the tokenizer reports for one byte.
    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] ev;
        t_len       len;
        logic [2:0] err;
        logic       past;
    } t_token_res;

    // Tracks the parse of the request head and holds the reports still owed.
    class t_token_tracker;
        t_stage      stage;
        t_len        count;
        logic [2:0]  halt_code;
        t_token_res  pending[$];
        int unsigned bad_results;

        function new();
            stage       = ST_METHOD;
            count       = '0;
            halt_code   = ERR_NONE;
            bad_results = 0;
        endfunction

        // Advance the parse by one accepted byte and queue its report.
        function void take_byte(logic [7:0] b);
            t_token_res r;
            logic       blank;
            logic       eol;
            r     = '0;
            blank = (b == CH_SP) || (b == CH_TAB);
            eol   = (b == CH_CR) || (b == CH_LF);
            if (halt_code != ERR_NONE) begin
                // Halted: nothing moves until reset.
            end else begin
                case (stage)
                    ST_PAST: begin
                        r.past = 1'b1;
                    end
                    ST_METHOD, ST_URI: begin
                        if (blank && count != '0) begin
                            r.ev  = (stage == ST_METHOD) ? EV_METHOD_END : EV_URI_END;
                            r.len = count;
                            count = '0;
                            stage = (stage == ST_METHOD) ? ST_SEP_URI : ST_SEP_VER;
                        end else if (blank || eol) begin
                            halt_code = (stage == ST_METHOD) ? ERR_METHOD : ERR_URI;
                        end else begin
                            if (count != '1) count = count + 1'b1;
                            r.kind = (stage == ST_METHOD) ? KIND_METHOD : KIND_URI;
                            r.len  = count;
                        end
                    end
                    ST_KEY: begin
                        if (b == CH_COLON && count != '0) begin
                            r.ev  = EV_KEY_END;
                            r.len = count;
                            count = '0;
                            stage = ST_SEP_VAL;
                        end else if (b == CH_COLON || blank || eol) begin
                            halt_code = ERR_KEY;
                        end else begin
                            if (count != '1) count = count + 1'b1;
                            r.kind = KIND_KEY;
                            r.len  = count;
                        end
                    end
                    ST_SEP_URI, ST_SEP_VER: begin
                        if (eol) begin
                            halt_code = (stage == ST_SEP_URI) ? ERR_URI : ERR_VERSION;
                        end else if (!blank) begin
                            r.kind = (stage == ST_SEP_URI) ? KIND_URI : KIND_VERSION;
                            stage  = (stage == ST_SEP_URI) ? ST_URI : ST_VERSION;
                            count  = t_len'(1);
                            r.len  = t_len'(1);
                        end
                    end
                    ST_VERSION, ST_VALUE, ST_SEP_VAL: begin
                        if (eol) begin
                            // An empty value still ends, with length zero.
                            r.ev  = (stage == ST_VERSION) ? EV_VERSION_END : EV_VALUE_END;
                            r.len = count;
                            count = '0;
                            stage = (b == CH_CR) ? ST_EOL : ST_LINE;
                        end else if (stage == ST_SEP_VAL && blank) begin
                            // Blanks between the colon and the value are skipped.
                        end else begin
                            if (stage == ST_SEP_VAL) begin
                                stage = ST_VALUE;
                                count = '0;
                            end
                            if (count != '1) count = count + 1'b1;
                            r.kind = (stage == ST_VERSION) ? KIND_VERSION : KIND_VALUE;
                            r.len  = count;
                        end
                    end
                    ST_EOL: begin
                        if (b == CH_LF) begin
                            stage = ST_LINE;
                        end else if (b != CH_CR) begin
                            halt_code = ERR_CRLF;
                        end
                    end
                    ST_LINE, ST_LINE_CR: begin
                        if (b == CH_CR) begin
                            stage = ST_LINE_CR;
                        end else if (b == CH_LF) begin
                            r.ev  = EV_HEAD_END;
                            stage = ST_PAST;
                        end else if (stage == ST_LINE_CR || b == CH_COLON || blank) begin
                            halt_code = ERR_KEY;
                        end else begin
                            stage  = ST_KEY;
                            count  = t_len'(1);
                            r.kind = KIND_KEY;
                            r.len  = t_len'(1);
                        end
                    end
                    default: begin
                        // Unused stage codes behave as halted.
                    end
                endcase
            end
            // Once halted, only the error code is reported.
            if (halt_code != ERR_NONE) r = '0;
            r.err = halt_code;
            pending.push_back(r);
        endfunction

        // Compare one result transfer with the oldest report owed.
        function void match_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            t_token_res            want;
            t_token_res            got;
            logic [OUT_DATA_W-1:0] fill;
            got.ev   = data[2:0];
            got.len  = data[3 +: LENGTH_BITS];
            got.err  = data[3 + LENGTH_BITS +: 3];
            got.kind = user[2:0];
            got.past = user[3];
            fill     = data >> OUT_FIELD_W;
            if (pending.size() == 0) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display("Unexpected result: kind %0d event %0d length %0d error %0d past %0d",
                             got.kind, got.ev, got.len, got.err, got.past);
                end
                return;
            end
            want = pending.pop_front();
            if (got != want || fill != '0) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display("Mismatch: expected kind %0d event %0d length %0d error %0d past %0d",
                             want.kind, want.ev, want.len, want.err, want.past);
                    $display("  actual kind %0d event %0d length %0d error %0d past %0d fill %0h",
                             got.kind, got.ev, got.len, got.err, got.past, fill);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;   // data_byte[7:0]
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;   // token_event, token_length, error_code, zero fill
    logic [OUT_USER_W-1:0] o_m_axis_tuser;   // token_kind, past_head

    t_token_tracker tracker;
    bit             steady;
    int unsigned    sent;

    http_request_head_tokenizer_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offer one byte after a random gap and wait until the transfer happens.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        tracker.take_byte(b);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // A random byte that is never CR or LF, optionally never a blank or a colon.
    function automatic logic [7:0] pick_byte(input bit allow_blank, input bit allow_colon);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == CH_CR || b == CH_LF ||
                   (!allow_blank && (b == CH_SP || b == CH_TAB)) ||
                   (!allow_colon && b == CH_COLON));
        return b;
    endfunction

    // One of the bytes that end or break a token: blank, CR or LF.
    function automatic logic [7:0] stop_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = CH_SP;
            1:       b = CH_TAB;
            2:       b = CH_CR;
            default: b = CH_LF;
        endcase
        return b;
    endfunction

    // Mostly short tokens, now and then a longer one.
    function automatic int unsigned token_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    endfunction

    // A token never starts with a blank; inner blanks and colons are optional.
    task automatic send_token(input int unsigned n, input bit inner_blank, input bit colon_ok);
        send_byte(pick_byte(1'b0, colon_ok));
        for (int unsigned i = 1; i < n; i++) send_byte(pick_byte(inner_blank, colon_ok));
    endtask

    task automatic send_blanks(input int unsigned n);
        repeat (n) send_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
    endtask

    task automatic send_line_end();
        repeat ($urandom_range(0, 2)) send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_header_line(input int unsigned value_len);
        send_token(token_len(), 1'b0, 1'b0);
        send_byte(CH_COLON);
        send_blanks($urandom_range(0, 2));
        if (value_len != 0) send_token(value_len, 1'b1, 1'b1);
        send_line_end();
    endtask

    task automatic send_noise(input int unsigned n);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Stimulus and end of run.
    initial begin
        int unsigned fate;
        tracker         = new();
        steady          = 1'b0;
        sent            = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fate = $urandom_range(0, 19);
        case (fate)
            0: begin
                // Empty method, or a line end inside the method.
                if ($urandom_range(0, 1)) begin
                    send_byte(stop_byte());
                end else begin
                    send_token(token_len(), 1'b0, 1'b1);
                    send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
                end
            end
            1: begin
                // Missing URI, or a line end inside the URI.
                send_token(token_len(), 1'b0, 1'b1);
                send_blanks($urandom_range(1, 3));
                if ($urandom_range(0, 1)) send_token(token_len(), 1'b0, 1'b1);
                send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
            end
            2: begin
                // Missing version.
                send_token(token_len(), 1'b0, 1'b1);
                send_blanks($urandom_range(1, 3));
                send_token(token_len(), 1'b0, 1'b1);
                send_blanks($urandom_range(1, 3));
                send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
            end
            default: begin
                // Request line with tab and space separators, the lowest and
                // highest byte values in the URI, and a repeated CR.
                send_text("G\t /");
                send_byte(8'h00);
                send_byte(8'hFF);
                send_text(" H\r\r\n");
                // An empty value, then blanks before a value that holds a
                // blank, ended by a bare LF.
                send_text("K:\r\nH: \tv a\n");

                // Well-formed header lines with random content.
                while (sent < RANDOM_BYTES) begin
                    steady = ($urandom_range(0, 7) == 0);
                    send_header_line(($urandom_range(0, 5) == 0) ? 0 : token_len());
                end
                steady = 1'b0;

                // How the head finishes.
                case ($urandom_range(0, 5))
                    0, 1: begin
                        send_line_end();
                    end
                    2: begin
                        // Stray byte after the CR that closes a value.
                        send_token(token_len(), 1'b0, 1'b0);
                        send_byte(CH_COLON);
                        send_token(token_len(), 1'b1, 1'b1);
                        send_byte(CH_CR);
                        send_byte(pick_byte(1'b1, 1'b1));
                    end
                    3: begin
                        // Colon or blank where a key should start.
                        case ($urandom_range(0, 2))
                            0:       send_byte(CH_COLON);
                            1:       send_byte(CH_SP);
                            default: send_byte(CH_TAB);
                        endcase
                    end
                    4: begin
                        // Lone CR followed by something other than LF.
                        send_byte(CH_CR);
                        send_byte(pick_byte(1'b1, 1'b1));
                    end
                    default: begin
                        // Blank or line end inside a key.
                        send_token(token_len(), 1'b0, 1'b0);
                        send_byte(stop_byte());
                    end
                endcase
            end
        endcase

        // Bytes after the head, either past it or while halted, up to the run size.
        send_noise(TAIL_BYTES);
        if (sent < ITEM_TARGET) send_noise(ITEM_TARGET - sent);
        i_s_axis_tvalid <= 1'b0;

        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (tracker.bad_results == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Result receiver with random stalls.
    initial begin
        int unsigned stall;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            tracker.match_result(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial begin
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/hrht_pkg.sv
rtl/core/http_request_head_tokenizer_unit.sv
tb/sv/tb.sv
